FILE: rtl/core/lpbe_pkg.sv
// Shared types and constants for the LED PWM / blink / breath engine.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package lpbe_pkg;

    // channel count, 1 to 4 (the item channel field is two bits)
    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PIN_W        = 4;

    localparam logic [7:0] LEVELS_RESET = 8'd20;
    localparam logic [15:0] BRIGHT_RESET = 16'h0100;

    // breath increment divider: 24-bit dividend, 16-bit divisor
    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_FLASH  = 3'd1,
        OP_BREATH = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_SET    = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  channel;
        logic [7:0]  step_ms;
        logic [7:0]  level;
        logic [7:0]  blinks_per_group;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [15:0] gap_time;
        logic [15:0] half_period;
    } t_item;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_breath;
        logic div_done;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/lpbe_if.sv
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lpbe_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [1:0]  channel;
    logic [7:0]  step_ms;
    logic [7:0]  level;
    logic [7:0]  blinks_per_group;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [15:0] gap_time;
    logic [15:0] half_period;

    modport source (
        output valid, opcode, channel, step_ms, level, blinks_per_group,
               on_time, off_time, gap_time, half_period,
        input  ready
    );
    modport sink (
        input  valid, opcode, channel, step_ms, level, blinks_per_group,
               on_time, off_time, gap_time, half_period,
        output ready
    );
endinterface

interface lpbe_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pin_levels;
    logic       cycle_done;

    modport source (output valid, pin_levels, cycle_done, input ready);
    modport sink   (input valid, pin_levels, cycle_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lpbe_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lpbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpbe_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [lpbe_pkg::DIVIDEND_W-1:0] i_dividend,
    input  wire logic [lpbe_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic      [lpbe_pkg::DIVIDEND_W-1:0] o_quotient,
    output logic                                 o_done
);
    import lpbe_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_dsr, n_dsr;
    logic [DIVISOR_W:0]    w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsr   = r_dsr;
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = DIVISOR_W'(w_trial - {1'b0, r_dsr});
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIVISOR_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

FILE: rtl/core/lpbe_dp.sv
// Datapath: item latch, levels register, per-channel state, result register.
// Depends on lpbe_pkg and lpbe_div.
`timescale 1ns / 1ps
`default_nettype none

module lpbe_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [7:0]                      i_cfg_wdata,
    input  wire lpbe_pkg::t_item                 i_item,
    input  wire lpbe_pkg::t_cmd                  i_cmd,
    output lpbe_pkg::t_status                    o_status,
    output logic      [lpbe_pkg::PIN_W-1:0]      o_pin_levels,
    output logic                                 o_cycle_done
);
    import lpbe_pkg::*;

    t_item                 r_item;
    logic [7:0]            r_levels;
    logic [7:0]            r_pwm_cnt   [NUM_CHANNELS];
    logic [15:0]           r_bright    [NUM_CHANNELS];
    logic                  r_ramp_down [NUM_CHANNELS];
    logic [15:0]           r_elapsed   [NUM_CHANNELS];
    logic [7:0]            r_blinks    [NUM_CHANNELS];
    logic [7:0]            n_pwm_cnt   [NUM_CHANNELS];
    logic [15:0]           n_bright    [NUM_CHANNELS];
    logic                  n_ramp_down [NUM_CHANNELS];
    logic [15:0]           n_elapsed   [NUM_CHANNELS];
    logic [7:0]            n_blinks    [NUM_CHANNELS];
    logic [PIN_W-1:0]      r_pins, n_pins;
    logic                  r_done, n_done;

    logic                  w_ch_ok;
    logic [CH_W-1:0]       w_ch;
    logic [15:0]           w_product;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic [DIVISOR_W-1:0]  w_divisor;
    logic [DIVIDEND_W-1:0] w_quotient;
    logic                  w_div_done;
    logic [15:0]           w_delta;

    assign w_ch_ok    = int'(r_item.channel) < NUM_CHANNELS;
    assign w_ch       = CH_W'(r_item.channel);
    assign w_product  = 16'(r_levels) * 16'(r_item.step_ms);
    assign w_dividend = {w_product, 8'h00};
    assign w_divisor  = (r_item.half_period == '0) ? DIVISOR_W'(1) : r_item.half_period;
    assign w_delta    = (w_quotient > DIVIDEND_W'(16'hFFFF)) ? 16'hFFFF
                                                              : w_quotient[15:0];

    lpbe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quotient),
        .o_done     (w_div_done)
    );

    assign o_status.is_breath = (r_item.opcode == OP_BREATH) && w_ch_ok;
    assign o_status.div_done  = w_div_done;

    always_comb begin
        logic [8:0]  v_next;
        logic [16:0] v_ms;
        logic [16:0] v_on_off;
        logic [16:0] v_b;
        logic [15:0] v_top;

        for (int c = 0; c < NUM_CHANNELS; c++) begin
            n_pwm_cnt[c]   = r_pwm_cnt[c];
            n_bright[c]    = r_bright[c];
            n_ramp_down[c] = r_ramp_down[c];
            n_elapsed[c]   = r_elapsed[c];
            n_blinks[c]    = r_blinks[c];
        end
        n_pins   = '0;
        n_done   = 1'b0;
        v_next   = '0;
        v_ms     = {1'b0, r_elapsed[w_ch]};
        v_on_off = {1'b0, r_item.on_time} + {1'b0, r_item.off_time};
        v_b      = {1'b0, r_bright[w_ch]};
        v_top    = {r_levels, 8'h00};

        case (r_item.opcode)
            OP_TICK: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (c < PIN_W) begin
                        n_pins[c % PIN_W] = r_pwm_cnt[c] < r_bright[c][15:8];
                    end
                    v_next = {1'b0, r_pwm_cnt[c]} + 9'd1;
                    n_pwm_cnt[c] = (v_next > {1'b0, r_levels}) ? 8'd0 : v_next[7:0];
                end
            end
            OP_FLASH: begin
                if (w_ch_ok) begin
                    if (r_blinks[w_ch] < r_item.blinks_per_group) begin
                        if (v_ms < {1'b0, r_item.on_time}) begin
                            n_bright[w_ch] = {r_item.level, 8'h00};
                        end else if (v_ms < v_on_off) begin
                            n_bright[w_ch] = '0;
                        end
                        if (v_ms >= v_on_off) begin
                            n_blinks[w_ch] = r_blinks[w_ch] + 8'd1;
                            v_ms = '0;
                        end
                    end else begin
                        if (v_ms < {1'b0, r_item.gap_time}) begin
                            n_bright[w_ch] = '0;
                        end else begin
                            n_blinks[w_ch] = '0;
                            v_ms   = '0;
                            n_done = 1'b1;
                        end
                    end
                    v_ms = v_ms + {9'd0, r_item.step_ms};
                    n_elapsed[w_ch] = v_ms[16] ? 16'hFFFF : v_ms[15:0];
                end
            end
            OP_BREATH: begin
                if (w_ch_ok) begin
                    if (!r_ramp_down[w_ch]) begin
                        v_b = v_b + {1'b0, w_delta};
                        if (v_b > {1'b0, v_top}) begin
                            v_b = {1'b0, v_top};
                            n_ramp_down[w_ch] = 1'b1;
                        end
                        n_bright[w_ch] = v_b[15:0];
                    end else if ({1'b0, w_delta} >= v_b) begin
                        n_bright[w_ch]    = '0;
                        n_ramp_down[w_ch] = 1'b0;
                        n_done            = 1'b1;
                    end else begin
                        n_bright[w_ch] = r_bright[w_ch] - w_delta;
                    end
                end
            end
            OP_CLEAR: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    n_bright[c]  = '0;
                    n_elapsed[c] = '0;
                    n_blinks[c]  = '0;
                end
            end
            OP_SET: begin
                if (w_ch_ok) begin
                    n_bright[w_ch] = {r_item.level, 8'h00};
                end
            end
            default: begin
                // unused opcodes: no state change, zero result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pwm_cnt[c]   <= '0;
                r_bright[c]    <= BRIGHT_RESET;
                r_ramp_down[c] <= 1'b0;
                r_elapsed[c]   <= '0;
                r_blinks[c]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_levels <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    r_pwm_cnt[c]   <= n_pwm_cnt[c];
                    r_bright[c]    <= n_bright[c];
                    r_ramp_down[c] <= n_ramp_down[c];
                    r_elapsed[c]   <= n_elapsed[c];
                    r_blinks[c]    <= n_blinks[c];
                end
            end
        end
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.commit) begin
            r_pins <= n_pins;
            r_done <= n_done;
        end
    end

    assign o_pin_levels = r_pins;
    assign o_cycle_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/core/lpbe_ctrl.sv
// Controller: sequences one item through decode, divide (breath only) and commit,
// and owns the input ready and result valid. Depends on lpbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpbe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire lpbe_pkg::t_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output lpbe_pkg::t_cmd         o_cmd
);
    import lpbe_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // result slot is free if empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_status.is_breath ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.div_start = i_status.is_breath;
            end
            S_DIV: begin
            end
            S_COMMIT: begin
                o_cmd.commit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/led_pwm_blink_breath_engine_top.sv
// PWM tick, flash, clear, set level: IDLE accepts, then DECODE, then COMMIT loads
//   the result once the slot is free; the next item is accepted back in IDLE.
// Breath step: DIV runs between DECODE and COMMIT, a one-bit-per-cycle restoring
//   divide by half_period, which makes it the slowest item.
// A result waiting in the output register does not block the next accept.
// Synchronous active-low reset: levels 20, brightness 1.0, other channel state zero.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the four-channel LED engine.
// Depends on lpbe_pkg, lpbe_if, lpbe_ctrl, lpbe_dp (and lpbe_div below it).
module led_pwm_blink_breath_engine_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    lpbe_in_if.sink         i_in,
    lpbe_out_if.source      o_out
);
    import lpbe_pkg::*;

    t_item   w_item;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_out_valid;

    // pack the incoming item for the latch in the datapath
    assign w_item.opcode           = i_in.opcode;
    assign w_item.channel          = i_in.channel;
    assign w_item.step_ms          = i_in.step_ms;
    assign w_item.level            = i_in.level;
    assign w_item.blinks_per_group = i_in.blinks_per_group;
    assign w_item.on_time          = i_in.on_time;
    assign w_item.off_time         = i_in.off_time;
    assign w_item.gap_time         = i_in.gap_time;
    assign w_item.half_period      = i_in.half_period;

    // sequencer: one item in flight, commit only when the result slot is free
    lpbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // all channel state, the divider and the result register live here
    lpbe_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (w_item),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_pin_levels (o_out.pin_levels),
        .o_cycle_done (o_out.cycle_done)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

`default_nettype wire

FILE: tb/led_pwm_blink_breath_engine_top_tb.sv
// Self-checking testbench for led_pwm_blink_breath_engine_top.
// Holds a cycle-free predictor of the four LED channels and checks every result.
// Depends on lpbe_pkg, lpbe_if and the RTL below the top level.
`timescale 1ns / 1ps

module led_pwm_blink_breath_engine_top_tb;

    import lpbe_pkg::*;

    // codes past OP_SET do nothing but still return an all-zero result
    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    localparam int IDLE_PCT     = 25;      // idle cycles per hundred, each side
    localparam int DRAIN_CYCLES = 32;      // margin covering a breath step, the slowest item
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 55;
    localparam int SAT_ITEMS    = 280;

    typedef struct packed {
        logic [3:0] pins;
        logic       done;
    } led_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    bit         calm = 1'b0;           // no idling on either side while set
    int         errors = 0;
    int         cycles = 0;

    lpbe_in_if  in_if();
    lpbe_out_if out_if();

    led_pwm_blink_breath_engine_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, far above the slowest legal run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: per-channel LED state plus the levels register.
    // ------------------------------------------------------------------
    logic [7:0]  levels_cfg;
    logic [7:0]  pwm_cnt   [NUM_CHANNELS];
    logic [15:0] bright    [NUM_CHANNELS];   // 8.8 fixed point
    logic        falling   [NUM_CHANNELS];   // breath ramp direction
    logic [15:0] elapsed   [NUM_CHANNELS];
    logic [7:0]  blink_cnt [NUM_CHANNELS];

    led_result_t pending_results[$];

    function automatic void reset_led_state();
        levels_cfg = LEVELS_RESET;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            pwm_cnt[c]   = '0;
            bright[c]    = BRIGHT_RESET;
            falling[c]   = 1'b0;
            elapsed[c]   = '0;
            blink_cnt[c] = '0;
        end
    endfunction

    // One PWM tick: a pin is on while its counter is below the integer level.
    function automatic logic [3:0] pwm_tick_pins();
        logic [3:0]  pins;
        int unsigned nxt;
        pins = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (c < PIN_W && pwm_cnt[c] < bright[c][15:8])
                pins[c] = 1'b1;
            nxt = pwm_cnt[c] + 1;
            pwm_cnt[c] = (nxt > levels_cfg) ? 8'd0 : 8'(nxt);
        end
        return pins;
    endfunction

    function automatic logic flash_done(input int c, input t_item it);
        int unsigned ms;
        int unsigned on_t;
        int unsigned off_t;
        logic        done;
        ms    = elapsed[c];
        on_t  = it.on_time;
        off_t = it.off_time;
        done  = 1'b0;
        if (blink_cnt[c] < it.blinks_per_group) begin
            if (ms < on_t)
                bright[c] = {it.level, 8'h00};
            else if (ms < on_t + off_t)
                bright[c] = '0;
            if (ms >= on_t + off_t) begin
                blink_cnt[c] = blink_cnt[c] + 8'd1;
                ms = 0;
            end
        end else begin
            if (ms < it.gap_time) begin
                bright[c] = '0;
            end else begin
                // gap over: whole group cycle complete
                blink_cnt[c] = '0;
                ms = 0;
                done = 1'b1;
            end
        end
        ms += it.step_ms;
        elapsed[c] = (ms > 16'hFFFF) ? 16'hFFFF : 16'(ms);
        return done;
    endfunction

    function automatic logic breath_done(input int c, input t_item it);
        int unsigned half;
        int unsigned delta;
        int unsigned b;
        int unsigned top;
        half = (it.half_period == 0) ? 1 : it.half_period;
        delta = (levels_cfg * it.step_ms * 256) / half;
        if (delta > 16'hFFFF)
            delta = 16'hFFFF;
        b   = bright[c];
        top = levels_cfg << 8;
        if (!falling[c]) begin
            b += delta;
            if (b > top) begin
                b = top;
                falling[c] = 1'b1;
            end
            bright[c] = 16'(b);
            return 1'b0;
        end
        if (delta >= b) begin
            bright[c]  = '0;
            falling[c] = 1'b0;
            return 1'b1;
        end
        bright[c] = 16'(b - delta);
        return 1'b0;
    endfunction

    // Advance the LED state by one accepted item and return its result.
    function automatic led_result_t predict_led_result(input t_item it);
        led_result_t r;
        int          c;
        r = '0;
        c = it.channel;
        case (it.opcode)
            OP_TICK: r.pins = pwm_tick_pins();
            OP_CLEAR: begin
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    bright[k]    = '0;
                    elapsed[k]   = '0;
                    blink_cnt[k] = '0;
                end
            end
            OP_FLASH:  if (c < NUM_CHANNELS) r.done = flash_done(c, it);
            OP_BREATH: if (c < NUM_CHANNELS) r.done = breath_done(c, it);
            OP_SET:    if (c < NUM_CHANNELS) bright[c] = {it.level, 8'h00};
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the in-order check.
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_if.ready = calm || ($urandom_range(99) >= IDLE_PCT);

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge clk) begin : check_results
        led_result_t want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", out_if.pin_levels, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.pin_levels !== want.pins)
                    report_mismatch("pin_levels", out_if.pin_levels, want.pins);
                if (out_if.cycle_done !== want.done)
                    report_mismatch("cycle_done", out_if.cycle_done, want.done);
            end
        end
    end

    // ------------------------------------------------------------------
    // Item side.
    // ------------------------------------------------------------------
    // Every field random, so bits the opcode ignores still toggle.
    function automatic t_item random_item();
        t_item it;
        it.opcode           = 3'($urandom);
        it.channel          = 2'($urandom);
        it.step_ms          = 8'($urandom);
        it.level            = 8'($urandom);
        it.blinks_per_group = 8'($urandom);
        it.on_time          = 16'($urandom);
        it.off_time         = 16'($urandom);
        it.gap_time         = 16'($urandom);
        it.half_period      = 16'($urandom);
        return it;
    endfunction

    // Present one item, hold it until accepted, then record its result.
    // Valid stays high afterward so the next item can follow back to back.
    task automatic send_item(input t_item it);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.opcode           = it.opcode;
        in_if.channel          = it.channel;
        in_if.step_ms          = it.step_ms;
        in_if.level            = it.level;
        in_if.blinks_per_group = it.blinks_per_group;
        in_if.on_time          = it.on_time;
        in_if.off_time         = it.off_time;
        in_if.gap_time         = it.gap_time;
        in_if.half_period      = it.half_period;
        in_if.valid            = 1'b1;
        do @(posedge clk); while (!in_if.ready);
        pending_results.push_back(predict_led_result(it));
    endtask

    task automatic do_tick();
        t_item it;
        it = random_item();
        it.opcode = OP_TICK;
        send_item(it);
    endtask

    task automatic do_set(input int ch, input int lv);
        t_item it;
        it = random_item();
        it.opcode  = OP_SET;
        it.channel = 2'(ch);
        it.level   = 8'(lv);
        send_item(it);
    endtask

    task automatic do_flash(input int ch, input int step, input int lv, input int grp,
                            input int on_t, input int off_t, input int gap_t);
        t_item it;
        it = random_item();
        it.opcode           = OP_FLASH;
        it.channel          = 2'(ch);
        it.step_ms          = 8'(step);
        it.level            = 8'(lv);
        it.blinks_per_group = 8'(grp);
        it.on_time          = 16'(on_t);
        it.off_time         = 16'(off_t);
        it.gap_time         = 16'(gap_t);
        send_item(it);
    endtask

    task automatic do_breath(input int ch, input int step, input int half);
        t_item it;
        it = random_item();
        it.opcode      = OP_BREATH;
        it.channel     = 2'(ch);
        it.step_ms     = 8'(step);
        it.half_period = 16'(half);
        send_item(it);
    endtask

    task automatic do_clear();
        t_item it;
        it = random_item();
        it.opcode = OP_CLEAR;
        send_item(it);
    endtask

    // Stop sending and wait for every pending result; the block is then idle.
    task automatic drain_results();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // levels is only written with the block idle.
    task automatic write_levels(input logic [7:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        levels_cfg = value;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Opcodes past OP_SET change nothing and return zero.
    task automatic test_unused_opcodes();
        t_item it;
        for (int op = OP_SET + 1; op <= OP_LAST_CODE; op++) begin
            it = random_item();
            it.opcode = 3'(op);
            send_item(it);
        end
    endtask

    // Reset brightness of one level, then set levels at both ends and tick.
    task automatic test_pwm_and_set_level();
        do_tick();
        do_tick();
        do_set(0, 0);
        do_set(1, 255);
        do_set(2, 1);
        do_set(3, 8'h80);
        do_tick();
        do_tick();
    endtask

    // One short group through on, off, count, gap and done; then extreme fields.
    task automatic test_flash_groups();
        repeat (5) do_flash(2, 3, 8'hFF, 1, 3, 2, 4);
        do_flash(0, 0, 8'h55, 0, 0, 0, 0);                    // empty group, no gap
        do_flash(1, 255, 0, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        do_tick();
    endtask

    // Saturated increment climbs to the peak, then falls to zero with done.
    task automatic test_breath_ramp();
        write_levels(8'd255);
        do_breath(3, 255, 1);
        do_breath(3, 255, 1);
        do_breath(3, 1, 0);                                   // zero half period
        do_breath(3, 0, 500);                                 // no movement
    endtask

    // With zero levels the counter never leaves zero and the breath peak is 0.
    task automatic test_zero_levels();
        write_levels(8'd0);
        do_tick();
        do_tick();
        do_breath(0, 10, 3);
    endtask

    task automatic test_clear_all();
        do_clear();
        do_tick();
    endtask

    // Phases of well-formed per-channel flash and breath sequences mixed with
    // ticks, set, clear and a little noise; levels changes between phases.
    task automatic test_random_traffic();
        int fl_grp [NUM_CHANNELS];
        int fl_on  [NUM_CHANNELS];
        int fl_off [NUM_CHANNELS];
        int fl_gap [NUM_CHANNELS];
        int fl_lv  [NUM_CHANNELS];
        int br_half[NUM_CHANNELS];
        int pick;
        int ch;
        logic [7:0] lv_choice;
        t_item it;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       lv_choice = 8'd1;
                1:       lv_choice = 8'd255;
                2:       lv_choice = 8'd0;
                3:       lv_choice = LEVELS_RESET;
                default: lv_choice = 8'($urandom_range(2, 254));
            endcase
            write_levels(lv_choice);
            calm = (ph == 3);               // one phase runs without idling
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                fl_grp[c]  = $urandom_range(0, 4);
                fl_on[c]   = $urandom_range(0, 40);
                fl_off[c]  = $urandom_range(0, 40);
                fl_gap[c]  = $urandom_range(0, 60);
                fl_lv[c]   = $urandom_range(0, 255);
                br_half[c] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 300);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                ch   = $urandom_range(NUM_CHANNELS - 1);
                if (pick < 30)
                    do_tick();
                else if (pick < 55)
                    do_flash(ch, $urandom_range(0, 30), fl_lv[ch], fl_grp[ch],
                             fl_on[ch], fl_off[ch], fl_gap[ch]);
                else if (pick < 80)
                    do_breath(ch, $urandom_range(0, 50), br_half[ch]);
                else if (pick < 85)
                    do_set(ch, $urandom_range(0, 255));
                else if (pick < 88)
                    do_clear();
                else begin
                    it = random_item();
                    send_item(it);
                end
            end
            calm = 1'b0;
        end
    endtask

    // Long gap with large steps: elapsed time pins at its maximum, then the
    // gap compare finally fails and the group cycle reports done.
    task automatic test_elapsed_saturation();
        do_clear();
        for (int n = 0; n < SAT_ITEMS; n++)
            do_flash(0, $urandom_range(240, 255), $urandom_range(0, 255), 0,
                     $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF), 16'hFFFF);
    endtask

    initial begin
        in_if.valid            = 1'b0;
        in_if.opcode           = OP_TICK;
        in_if.channel          = '0;
        in_if.step_ms          = '0;
        in_if.level            = '0;
        in_if.blinks_per_group = '0;
        in_if.on_time          = '0;
        in_if.off_time         = '0;
        in_if.gap_time         = '0;
        in_if.half_period      = '0;
        out_if.ready           = 1'b0;
        reset_led_state();

        // synchronous reset held low, then released off the active edge
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_unused_opcodes();
        test_pwm_and_set_level();
        test_flash_groups();
        test_breath_ramp();
        test_zero_levels();
        test_clear_all();
        test_random_traffic();
        test_elapsed_saturation();

        // wait out every pending result plus the breath latency
        drain_results();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
